// File: rtl/attitude_complementary_filter_assert.svh
// Assertion macros used by the attitude filter controller.
`ifndef ATTITUDE_COMPLEMENTARY_FILTER_ASSERT_SVH
`define ATTITUDE_COMPLEMENTARY_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ACF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("acf assertion failed");
`define ACF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("acf assertion failed");
`else
`define ACF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ACF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/acf_pkg.sv
`default_nettype none
package acf_pkg;

    localparam int ACF_CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int IDX_W            = 5;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_STEP   = 8'd1;

    localparam logic [16:0] ALPHA_ONE   = 17'd65536;
    localparam logic [16:0] ALPHA_RESET = 17'd58982;
    localparam logic [19:0] STEP_RESET  = 20'd32768;

    // angles: Q16 hundredths of a degree
    localparam logic [39:0] FULL_TURN = 40'd2359296000;
    localparam logic [39:0] HALF_TURN = 40'd1179648000;
    localparam logic signed [32:0] QUARTER_TURN = 33'sd589824000;

    // offsets that make the value to wrap positive before the reduction
    localparam logic signed [40:0] WRAP_OFS_BIG   = 41'(64'd1179648000 + 64'd75497472000);
    localparam logic signed [40:0] WRAP_OFS_SMALL = 41'(64'd1179648000 + 64'd2359296000);
    localparam logic [IDX_W-1:0] WRAP_BIG_K   = 5'd5;
    localparam logic [IDX_W-1:0] WRAP_SMALL_K = 5'd1;

    typedef enum logic [3:0] {
        OP_NONE, OP_GMUL, OP_WINIT_G, OP_WINIT_Z, OP_WINIT_B, OP_WSTEP,
        OP_STORE_G, OP_STORE_Z, OP_STORE_B, OP_CINIT, OP_CSTEP, OP_BMUL
    } op_t;

    typedef enum logic [1:0] {CH_YAW, CH_ROLL, CH_PITCH} chan_t;

    typedef struct packed {
        logic             load;
        logic             publish;
        op_t              op;
        chan_t            chan;
        logic [IDX_W-1:0] idx;
    } acf_cmd_t;

    function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd294912000;
            5'd1:  v = 32'd174096719;
            5'd2:  v = 32'd91987925;
            5'd3:  v = 32'd46694507;
            5'd4:  v = 32'd23437865;
            5'd5:  v = 32'd11730358;
            5'd6:  v = 32'd5866610;
            5'd7:  v = 32'd2933484;
            5'd8:  v = 32'd1466764;
            5'd9:  v = 32'd733385;
            5'd10: v = 32'd366693;
            5'd11: v = 32'd183346;
            5'd12: v = 32'd91673;
            5'd13: v = 32'd45837;
            5'd14: v = 32'd22918;
            5'd15: v = 32'd11459;
            5'd16: v = 32'd5730;
            5'd17: v = 32'd2865;
            5'd18: v = 32'd1432;
            5'd19: v = 32'd716;
            5'd20: v = 32'd358;
            5'd21: v = 32'd179;
            5'd22: v = 32'd90;
            5'd23: v = 32'd45;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/acf_datapath.sv
`default_nettype none
module acf_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire acf_pkg::acf_cmd_t               cmd,
    input  wire logic                            cfg_valid,
    input  wire logic [acf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [acf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic signed [15:0]              s_accel_x,
    input  wire logic signed [15:0]              s_accel_y,
    input  wire logic signed [15:0]              s_accel_z,
    input  wire logic signed [15:0]              s_gyro_x,
    input  wire logic signed [15:0]              s_gyro_y,
    input  wire logic signed [15:0]              s_gyro_z,
    output logic signed [15:0]                   m_roll_out,
    output logic signed [15:0]                   m_pitch_out,
    output logic signed [15:0]                   m_yaw_out
);
    import acf_pkg::*;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [16:0] alpha_reg;
    logic [19:0] step_reg;
    logic signed [31:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [31:0] roll_pred_reg, pitch_pred_reg, roll_acc_reg, pitch_acc_reg;
    logic signed [36:0] prod_reg;
    logic signed [49:0] pa_reg, pb_reg;
    logic [39:0] w_reg;
    logic signed [36:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic czero_reg;
    logic signed [15:0] roll_out_reg, pitch_out_reg, yaw_out_reg;

    logic signed [15:0] g_sel;
    logic signed [31:0] angle_sel, pred_sel, acc_sel;
    logic [16:0] a_sat;
    logic signed [40:0] ang_ext, prod_ext, z_ext, b_ext;
    logic signed [50:0] bsum;
    logic [39:0] cand, wdiff;
    logic signed [31:0] wres;
    logic signed [17:0] y0, x0;
    logic signed [17:0] x1, y1;
    logic signed [32:0] z1;
    logic signed [36:0] dx, dy;
    logic signed [32:0] at;

    always_comb begin
        case (cmd.chan)
            CH_YAW:   begin g_sel = gz_reg; angle_sel = yaw_reg;   end
            CH_ROLL:  begin g_sel = gx_reg; angle_sel = roll_reg;  end
            default:  begin g_sel = gy_reg; angle_sel = pitch_reg; end
        endcase
        pred_sel = (cmd.chan == CH_ROLL) ? roll_pred_reg : pitch_pred_reg;
        acc_sel  = (cmd.chan == CH_ROLL) ? roll_acc_reg  : pitch_acc_reg;
        a_sat    = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;

        ang_ext  = 41'(angle_sel);
        prod_ext = 41'(prod_reg);
        z_ext    = czero_reg ? 41'sd0 : 41'(cz_reg);
        bsum     = 51'(pa_reg) + 51'(pb_reg) + 51'sd32768;
        b_ext    = 41'($signed(bsum[50:16]));

        cand  = FULL_TURN << cmd.idx;
        wdiff = w_reg - HALF_TURN;
        wres  = $signed(wdiff[31:0]);

        // CORDIC setup: rotate by a quarter turn so that x is not negative
        y0 = (cmd.chan == CH_ROLL) ? 18'(ay_reg) : -18'(ax_reg);
        x0 = 18'(az_reg);
        if (x0 < 0) begin
            if (y0 >= 0) begin
                x1 = y0; y1 = -x0; z1 = QUARTER_TURN;
            end else begin
                x1 = -y0; y1 = x0; z1 = -QUARTER_TURN;
            end
        end else begin
            x1 = x0; y1 = y0; z1 = 33'sd0;
        end

        dx = cy_reg >>> cmd.idx;
        dy = cx_reg >>> cmd.idx;
        at = $signed({1'b0, atan_entry(cmd.idx)});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RESET;
            step_reg  <= STEP_RESET;
            roll_reg  <= '0;
            pitch_reg <= '0;
            yaw_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_BLEND_ALPHA: alpha_reg <= cfg_data[16:0];
                    CFG_GYRO_STEP:   step_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_STORE_G && cmd.chan == CH_YAW) yaw_reg <= wres;
            if (cmd.op == OP_STORE_B) begin
                if (cmd.chan == CH_ROLL) roll_reg <= wres;
                else pitch_reg <= wres;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg <= s_accel_x; ay_reg <= s_accel_y; az_reg <= s_accel_z;
            gx_reg <= s_gyro_x;  gy_reg <= s_gyro_y;  gz_reg <= s_gyro_z;
        end
        if (cmd.publish) begin
            roll_out_reg  <= roll_reg[31:16];
            pitch_out_reg <= pitch_reg[31:16];
            yaw_out_reg   <= yaw_reg[31:16];
        end
        case (cmd.op)
            OP_GMUL:    prod_reg <= g_sel * $signed({1'b0, step_reg});
            OP_BMUL: begin
                pa_reg <= $signed({1'b0, a_sat}) * pred_sel;
                pb_reg <= $signed({1'b0, ALPHA_ONE - a_sat}) * acc_sel;
            end
            OP_WINIT_G: w_reg <= 40'(ang_ext + prod_ext + WRAP_OFS_BIG);
            OP_WINIT_Z: w_reg <= 40'(z_ext + WRAP_OFS_SMALL);
            OP_WINIT_B: w_reg <= 40'(b_ext + WRAP_OFS_SMALL);
            OP_WSTEP:   if (w_reg >= cand) w_reg <= w_reg - cand;
            OP_STORE_G: begin
                if (cmd.chan == CH_ROLL) roll_pred_reg <= wres;
                else if (cmd.chan == CH_PITCH) pitch_pred_reg <= wres;
            end
            OP_STORE_Z: begin
                if (cmd.chan == CH_ROLL) roll_acc_reg <= wres;
                else pitch_acc_reg <= wres;
            end
            OP_CINIT: begin
                cx_reg    <= 37'({{3{x1[17]}}, x1, 16'h0000});
                cy_reg    <= 37'({{3{y1[17]}}, y1, 16'h0000});
                cz_reg    <= z1;
                czero_reg <= (x0 == 18'sd0) && (y0 == 18'sd0);
            end
            OP_CSTEP: begin
                if (cy_reg > 0) begin
                    cx_reg <= cx_reg + dx; cy_reg <= cy_reg - dy; cz_reg <= cz_reg + at;
                end else begin
                    cx_reg <= cx_reg - dx; cy_reg <= cy_reg + dy; cz_reg <= cz_reg - at;
                end
            end
            default: ;
        endcase
    end

    assign m_roll_out  = roll_out_reg;
    assign m_pitch_out = pitch_out_reg;
    assign m_yaw_out   = yaw_out_reg;

endmodule
`default_nettype wire

// File: rtl/acf_controller.sv
`default_nettype none
`include "attitude_complementary_filter_assert.svh"
module acf_controller #(
    parameter int CORDIC_STEPS = acf_pkg::ACF_CORDIC_STEPS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output acf_pkg::acf_cmd_t  cmd
);
    import acf_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_GMUL   = 15'b000000000000010,
        ST_GWINIT = 15'b000000000000100,
        ST_GWSTEP = 15'b000000000001000,
        ST_GSTORE = 15'b000000000010000,
        ST_CINIT  = 15'b000000000100000,
        ST_CSTEP  = 15'b000000001000000,
        ST_CWINIT = 15'b000000010000000,
        ST_CWSTEP = 15'b000000100000000,
        ST_CSTORE = 15'b000001000000000,
        ST_BMUL   = 15'b000010000000000,
        ST_BWINIT = 15'b000100000000000,
        ST_BWSTEP = 15'b001000000000000,
        ST_BSTORE = 15'b010000000000000,
        ST_DONE   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    chan_t chan_reg, chan_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        chan_next    = chan_reg;
        cnt_next     = cnt_reg;
        cmd.load     = 1'b0;
        cmd.publish  = 1'b0;
        cmd.op       = OP_NONE;
        cmd.chan     = chan_reg;
        cmd.idx      = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    chan_next  = CH_YAW;
                    state_next = ST_GMUL;
                end
            end
            ST_GMUL: begin
                cmd.op = OP_GMUL;
                state_next = ST_GWINIT;
            end
            ST_GWINIT: begin
                cmd.op = OP_WINIT_G;
                cnt_next = WRAP_BIG_K;
                state_next = ST_GWSTEP;
            end
            ST_GWSTEP: begin
                cmd.op = OP_WSTEP;
                if (cnt_reg == '0) state_next = ST_GSTORE;
                else cnt_next = cnt_reg - 1'b1;
            end
            ST_GSTORE: begin
                cmd.op = OP_STORE_G;
                unique case (chan_reg)
                    CH_YAW:  begin chan_next = CH_ROLL;  state_next = ST_GMUL;  end
                    CH_ROLL: begin chan_next = CH_PITCH; state_next = ST_GMUL;  end
                    default: begin chan_next = CH_ROLL;  state_next = ST_CINIT; end
                endcase
            end
            ST_CINIT: begin
                cmd.op = OP_CINIT;
                cnt_next = '0;
                state_next = ST_CSTEP;
            end
            ST_CSTEP: begin
                cmd.op = OP_CSTEP;
                if (cnt_reg == IDX_W'(CORDIC_STEPS - 1)) state_next = ST_CWINIT;
                else cnt_next = cnt_reg + 1'b1;
            end
            ST_CWINIT: begin
                cmd.op = OP_WINIT_Z;
                cnt_next = WRAP_SMALL_K;
                state_next = ST_CWSTEP;
            end
            ST_CWSTEP: begin
                cmd.op = OP_WSTEP;
                if (cnt_reg == '0) state_next = ST_CSTORE;
                else cnt_next = cnt_reg - 1'b1;
            end
            ST_CSTORE: begin
                cmd.op = OP_STORE_Z;
                if (chan_reg == CH_ROLL) begin
                    chan_next = CH_PITCH; state_next = ST_CINIT;
                end else begin
                    chan_next = CH_ROLL; state_next = ST_BMUL;
                end
            end
            ST_BMUL: begin
                cmd.op = OP_BMUL;
                state_next = ST_BWINIT;
            end
            ST_BWINIT: begin
                cmd.op = OP_WINIT_B;
                cnt_next = WRAP_SMALL_K;
                state_next = ST_BWSTEP;
            end
            ST_BWSTEP: begin
                cmd.op = OP_WSTEP;
                if (cnt_reg == '0) state_next = ST_BSTORE;
                else cnt_next = cnt_reg - 1'b1;
            end
            ST_BSTORE: begin
                cmd.op = OP_STORE_B;
                if (chan_reg == CH_ROLL) begin
                    chan_next = CH_PITCH; state_next = ST_BMUL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand over once the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.publish  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            chan_reg    <= CH_YAW;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chan_reg    <= chan_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    `ACF_ASSERT_NXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state_reg == ST_GMUL)
    `ACF_ASSERT_IMP(a_publish_free, aclk, aresetn, cmd.publish, !m_valid_reg || m_ready)
    `ACF_ASSERT_IMP(a_cordic_cnt, aclk, aresetn, state_reg == ST_CSTEP, cnt_reg < IDX_W'(CORDIC_STEPS))
    `ACF_ASSERT_IMP(a_wrap_cnt, aclk, aresetn, cmd.op == OP_WSTEP, cnt_reg <= WRAP_BIG_K)

endmodule
`default_nettype wire

// File: rtl/attitude_complementary_filter.sv
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | accel_x/y/z, gyro_x/y/z (16-bit signed)
// m_      | out       | m_valid / m_ready  | roll_out, pitch_out, yaw_out (16-bit signed)
// cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (0 alpha, 1 step)
// One item at a time (s_ready only while idle): three gyro integrations
// with a 6-step modulo reduction, two CORDIC passes on one shared shift-add
// unit, and two blends. The output register lets the next item in while a
// result waits. Reset is synchronous; cfg_ready is always high.
`default_nettype none
module attitude_complementary_filter #(
    parameter int CORDIC_STEPS = acf_pkg::ACF_CORDIC_STEPS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [15:0]              s_accel_x,
    input  wire logic signed [15:0]              s_accel_y,
    input  wire logic signed [15:0]              s_accel_z,
    input  wire logic signed [15:0]              s_gyro_x,
    input  wire logic signed [15:0]              s_gyro_y,
    input  wire logic signed [15:0]              s_gyro_z,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [15:0]                   m_roll_out,
    output logic signed [15:0]                   m_pitch_out,
    output logic signed [15:0]                   m_yaw_out,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [acf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [acf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import acf_pkg::*;

    acf_cmd_t cmd;

    assign cfg_ready = 1'b1;

    acf_controller #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    acf_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_accel_x   (s_accel_x),
        .s_accel_y   (s_accel_y),
        .s_accel_z   (s_accel_z),
        .s_gyro_x    (s_gyro_x),
        .s_gyro_y    (s_gyro_y),
        .s_gyro_z    (s_gyro_z),
        .m_roll_out  (m_roll_out),
        .m_pitch_out (m_pitch_out),
        .m_yaw_out   (m_yaw_out)
    );

endmodule
`default_nettype wire
